// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check sampled on the rising clock edge, off while reset is low
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same check without a reset term
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/jfcm_pkg.sv -----
// constants, types and helper functions for the jet false-color map
// no dependencies
`timescale 1ns / 1ps

package jfcm_pkg;

    localparam int SAMPLE_WIDTH  = 32;
    localparam int FRACTION_BITS = 16;
    // quotient bits of 8*diff/range with the fraction bits kept
    localparam int QUOT_BITS     = FRACTION_BITS + 3;
    // sample difference, one bit wider than a sample
    localparam int REM_W         = SAMPLE_WIDTH + 1;
    // gray level in [0,8]
    localparam int GRAY_W        = QUOT_BITS + 1;
    // ramp position in [0,2]
    localparam int T_W           = FRACTION_BITS + 2;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    // register word index, paddr[ADDR_W-1:2]
    localparam logic REG_MIN_IDX = 1'b0;
    localparam logic REG_MAX_IDX = 1'b1;

    localparam logic [SAMPLE_WIDTH-1:0] RANGE_MIN_RST = SAMPLE_WIDTH'(0);
    localparam logic [SAMPLE_WIDTH-1:0] RANGE_MAX_RST = SAMPLE_WIDTH'(1) << FRACTION_BITS;

    // channel source codes
    localparam logic [1:0] CH_ZERO = 2'd0;
    localparam logic [1:0] CH_FULL = 2'd1;
    localparam logic [1:0] CH_RAMP = 2'd2;

    localparam logic [7:0] NO_DATA_LEVEL = 8'd128;
    localparam logic [7:0] LEVEL_MAX     = 8'd255;

    typedef struct packed {
        logic no_data;
        logic zero;
        logic sat;
    } ctl_t;

    typedef struct packed {
        logic [1:0]     mode;
        logic [T_W-1:0] pos;
    } chan_t;

    // floor((t*255 + one) / (2*one)), clamped to 255
    function automatic logic [7:0] ramp(input logic [T_W-1:0] t);
        logic [T_W+8:0] prod;
        logic [T_W+8:0] lvl;
        prod = ({9'b0, t} << 8) - {9'b0, t} + ((T_W+9)'(1) << FRACTION_BITS);
        lvl  = prod >> (FRACTION_BITS + 1);
        if (lvl > (T_W+9)'(LEVEL_MAX))
            return LEVEL_MAX;
        return lvl[7:0];
    endfunction

endpackage

// ----- rtl/jet_false_color_map.sv -----
// jet false-color map top level: config registers and the full pipeline
// depends on jfcm_pkg
`timescale 1ns / 1ps

// Maps one signed Q16.16 sample per clock to the 8-bit red, green and blue of
// the jet color scale. The sample is scaled against range_min / range_max
// (APB registers at byte addresses 0 and 4) to gray = 8*(v-min)/(max-min) with
// 16 fraction bits, clamped to [0,8]; samples below the minimum give gray 0,
// samples at or above the maximum give gray 8, and a maximum not above the
// minimum gives gray 0. A transaction with tuser set (no data) comes out as
// grey 128 on all three channels. The block takes a new transaction in every
// cycle and returns each result in order through its registered stages: one stage
// forms the difference, one classifies it, 19 stages each make one quotient
// bit of the restoring divider, and three more pick the gray level, select the
// color segment and evaluate the ramps. Only backpressure on the output side
// stalls it; the whole pipe then holds together. Write the range registers
// only while no transaction is in flight.
module jet_false_color_map
    import jfcm_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [ADDR_W-1:0]       paddr,
    input  logic [DATA_W-1:0]       pwdata,
    output logic [DATA_W-1:0]       prdata,
    output logic                    pready,
    // sample input
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [SAMPLE_WIDTH-1:0] s_axis_tdata,   // [31:0] sample_value
    input  logic                    s_axis_tuser,   // [0] no_data
    // color output
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [23:0]             m_axis_tdata    // [7:0] red, [15:8] green, [23:16] blue
);

    // ------------------------------------------------------------------
    // configuration registers; the range is kept alongside so the
    // divider never has to subtract the two
    // ------------------------------------------------------------------
    logic [SAMPLE_WIDTH-1:0] range_min_reg;
    logic [SAMPLE_WIDTH-1:0] range_max_reg;
    logic signed [REM_W-1:0] span_reg;
    logic signed [REM_W-1:0] span_next;
    logic                    cfg_wr;
    logic                    cfg_idx;
    logic [SAMPLE_WIDTH-1:0] cfg_data;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign cfg_idx  = paddr[ADDR_W-1];
    assign cfg_data = pwdata[SAMPLE_WIDTH-1:0];

    always_comb
    begin
        if (cfg_idx == REG_MIN_IDX)
            span_next = $signed({range_max_reg[SAMPLE_WIDTH-1], range_max_reg})
                      - $signed({cfg_data[SAMPLE_WIDTH-1], cfg_data});
        else
            span_next = $signed({cfg_data[SAMPLE_WIDTH-1], cfg_data})
                      - $signed({range_min_reg[SAMPLE_WIDTH-1], range_min_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_min_reg <= RANGE_MIN_RST;
            range_max_reg <= RANGE_MAX_RST;
            span_reg      <= REM_W'(RANGE_MAX_RST);
        end
        else if (cfg_wr)
        begin
            span_reg <= span_next;
            if (cfg_idx == REG_MIN_IDX)
                range_min_reg <= cfg_data;
            else
                range_max_reg <= cfg_data;
        end
    end

    // read back sign extended
    always_comb
    begin
        unique case (cfg_idx)
            REG_MIN_IDX: prdata = DATA_W'($signed(range_min_reg));
            REG_MAX_IDX: prdata = DATA_W'($signed(range_max_reg));
            default:     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // pipeline advance: everything moves unless the output is held
    // ------------------------------------------------------------------
    logic adv;
    logic out_vld_reg;

    assign adv           = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // stage 1: difference to the minimum
    logic                    s1_vld_reg;
    logic signed [REM_W-1:0] s1_diff_reg;
    logic                    s1_nd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_vld_reg <= 1'b0;
        else if (adv)
            s1_vld_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_diff_reg <= $signed({s_axis_tdata[SAMPLE_WIDTH-1], s_axis_tdata})
                         - $signed({range_min_reg[SAMPLE_WIDTH-1], range_min_reg});
            s1_nd_reg   <= s_axis_tuser;
        end
    end

    // stage 2 (divider entry 0): classify the difference, load the remainder
    logic             div_vld_reg  [0:QUOT_BITS];
    logic [REM_W-1:0] div_rem_reg  [0:QUOT_BITS];
    logic [QUOT_BITS-1:0] div_quot_reg [0:QUOT_BITS];
    ctl_t             div_ctl_reg  [0:QUOT_BITS];
    ctl_t             ctl_next;

    always_comb
    begin
        ctl_next.no_data = s1_nd_reg;
        ctl_next.zero    = (span_reg <= 0) || (s1_diff_reg <= 0);
        ctl_next.sat     = (s1_diff_reg >= span_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_vld_reg[0] <= 1'b0;
        else if (adv)
            div_vld_reg[0] <= s1_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            div_rem_reg[0]  <= s1_diff_reg;
            div_quot_reg[0] <= '0;
            div_ctl_reg[0]  <= ctl_next;
        end
    end

    // restoring divider, one quotient bit per stage
    genvar k;
    generate
        for (k = 1; k <= QUOT_BITS; k++)
        begin : g_div
            logic [REM_W:0]   shifted;
            logic [REM_W:0]   den;
            logic [REM_W:0]   sub;
            logic             ge;
            logic [REM_W-1:0] rem_next;

            assign shifted  = {div_rem_reg[k-1], 1'b0};
            assign den      = {1'b0, span_reg};
            assign sub      = shifted - den;
            assign ge       = shifted >= den;
            assign rem_next = ge ? sub[REM_W-1:0] : shifted[REM_W-1:0];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    div_vld_reg[k] <= 1'b0;
                else if (adv)
                    div_vld_reg[k] <= div_vld_reg[k-1];
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    div_rem_reg[k]  <= rem_next;
                    div_quot_reg[k] <= {div_quot_reg[k-1][QUOT_BITS-2:0], ge};
                    div_ctl_reg[k]  <= div_ctl_reg[k-1];
                end
            end
        end
    endgenerate

    // gray stage: apply saturation
    localparam logic [GRAY_W-1:0] ONE_G   = GRAY_W'(1) << FRACTION_BITS;
    localparam logic [GRAY_W-1:0] THREE_G = GRAY_W'(3) << FRACTION_BITS;
    localparam logic [GRAY_W-1:0] FIVE_G  = GRAY_W'(5) << FRACTION_BITS;
    localparam logic [GRAY_W-1:0] SEVEN_G = GRAY_W'(7) << FRACTION_BITS;
    localparam logic [GRAY_W-1:0] EIGHT_G = GRAY_W'(8) << FRACTION_BITS;
    localparam logic [GRAY_W-1:0] NINE_G  = GRAY_W'(9) << FRACTION_BITS;

    logic              gr_vld_reg;
    logic [GRAY_W-1:0] gr_level_reg;
    logic [GRAY_W-1:0] gr_level_next;
    logic              gr_nd_reg;
    ctl_t              last_ctl;

    assign last_ctl = div_ctl_reg[QUOT_BITS];

    always_comb
    begin
        if (last_ctl.zero)
            gr_level_next = '0;
        else if (last_ctl.sat)
            gr_level_next = EIGHT_G;
        else
            gr_level_next = {1'b0, div_quot_reg[QUOT_BITS]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gr_vld_reg <= 1'b0;
        else if (adv)
            gr_vld_reg <= div_vld_reg[QUOT_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gr_level_reg <= gr_level_next;
            gr_nd_reg    <= last_ctl.no_data;
        end
    end

    // segment stage: pick what drives each channel
    logic  seg_vld_reg;
    logic  seg_nd_reg;
    chan_t seg_r_reg, seg_g_reg, seg_b_reg;
    chan_t seg_r_next, seg_g_next, seg_b_next;
    logic [GRAY_W-1:0] g_up1, g_dn1, g_dn3, g_5dn, g_7dn, g_9dn;

    assign g_up1 = gr_level_reg + ONE_G;
    assign g_dn1 = gr_level_reg - ONE_G;
    assign g_dn3 = gr_level_reg - THREE_G;
    assign g_5dn = FIVE_G - gr_level_reg;
    assign g_7dn = SEVEN_G - gr_level_reg;
    assign g_9dn = NINE_G - gr_level_reg;

    always_comb
    begin
        seg_r_next = '{mode: CH_ZERO, pos: '0};
        seg_g_next = '{mode: CH_ZERO, pos: '0};
        seg_b_next = '{mode: CH_ZERO, pos: '0};
        if (gr_level_reg <= ONE_G)
        begin
            // blue rises from half
            seg_b_next = '{mode: CH_RAMP, pos: g_up1[T_W-1:0]};
        end
        else if (gr_level_reg <= THREE_G)
        begin
            seg_g_next = '{mode: CH_RAMP, pos: g_dn1[T_W-1:0]};
            seg_b_next.mode = CH_FULL;
        end
        else if (gr_level_reg <= FIVE_G)
        begin
            seg_r_next = '{mode: CH_RAMP, pos: g_dn3[T_W-1:0]};
            seg_g_next.mode = CH_FULL;
            seg_b_next = '{mode: CH_RAMP, pos: g_5dn[T_W-1:0]};
        end
        else if (gr_level_reg <= SEVEN_G)
        begin
            seg_r_next.mode = CH_FULL;
            seg_g_next = '{mode: CH_RAMP, pos: g_7dn[T_W-1:0]};
        end
        else
        begin
            // red falls back to half
            seg_r_next = '{mode: CH_RAMP, pos: g_9dn[T_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seg_vld_reg <= 1'b0;
        else if (adv)
            seg_vld_reg <= gr_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            seg_r_reg  <= seg_r_next;
            seg_g_reg  <= seg_g_next;
            seg_b_reg  <= seg_b_next;
            seg_nd_reg <= gr_nd_reg;
        end
    end

    // output stage: evaluate ramps, substitute grey for missing samples
    logic [7:0] red_reg, green_reg, blue_reg;
    logic [7:0] red_next, green_next, blue_next;

    function automatic logic [7:0] chan_level(input chan_t c);
        logic [7:0] lvl;
        case (c.mode)
            CH_FULL: lvl = LEVEL_MAX;
            CH_RAMP: lvl = ramp(c.pos);
            default: lvl = '0;
        endcase
        return lvl;
    endfunction

    always_comb
    begin
        if (seg_nd_reg)
        begin
            red_next   = NO_DATA_LEVEL;
            green_next = NO_DATA_LEVEL;
            blue_next  = NO_DATA_LEVEL;
        end
        else
        begin
            red_next   = chan_level(seg_r_reg);
            green_next = chan_level(seg_g_reg);
            blue_next  = chan_level(seg_b_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (adv)
            out_vld_reg <= seg_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {blue_reg, green_reg, red_reg};

endmodule

// ----- rtl/jfcm_checker.sv -----
// port-level checks for the jet false-color map, bound to the top level
// depends on jfcm_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module jfcm_checker
    import jfcm_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    psel,
    input logic                    penable,
    input logic                    pwrite,
    input logic [ADDR_W-1:0]       paddr,
    input logic [DATA_W-1:0]       pwdata,
    input logic [DATA_W-1:0]       prdata,
    input logic                    pready,
    input logic                    s_axis_tready,
    input logic                    m_axis_tvalid,
    input logic                    m_axis_tready,
    input logic [23:0]             m_axis_tdata
);

    // a held result keeps its color
    `ASSERT_CLK(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "output transaction changed while stalled")

    // input only stalls behind a held output
    `ASSERT_CLK(a_in_ready, clk, rst_n, !m_axis_tvalid || m_axis_tready |-> s_axis_tready, "input stalled without output backpressure")

    // every jet color has a channel at a rail, unless it is the no-data grey
    `ASSERT_CLK(a_jet_rail, clk, rst_n, m_axis_tvalid |-> m_axis_tdata[7:0] == 8'd0 || m_axis_tdata[7:0] == 8'd255 || m_axis_tdata[15:8] == 8'd0 || m_axis_tdata[15:8] == 8'd255 || m_axis_tdata[23:16] == 8'd0 || m_axis_tdata[23:16] == 8'd255 || m_axis_tdata == 24'h808080, "output color off the jet scale")

    // minimum register reads back what was written
    `ASSERT_CLK(a_min_readback, clk, rst_n, psel && penable && pwrite && pready && paddr[ADDR_W-1] == REG_MIN_IDX |=> paddr[ADDR_W-1] != REG_MIN_IDX || prdata == $past(pwdata), "range_min read back wrong")

endmodule

bind jet_false_color_map jfcm_checker u_jfcm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/jet_false_color_map_tb.sv -----
// self-checking bench for jet_false_color_map: streams samples, predicts each color
// depends on jfcm_pkg and the jet_false_color_map rtl
`timescale 1ns / 1ps

module jet_false_color_map_tb;
    import jfcm_pkg::*;

    typedef longint unsigned u64_t;

    // color as it travels on m_axis_tdata: red in the lowest byte
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } color_t;

    typedef struct {
        logic [SAMPLE_WIDTH-1:0] value;
        logic                    no_data;
    } sample_item_t;

    localparam u64_t ONE          = u64_t'(1) << FRACTION_BITS;
    localparam int   IDLE_PCT     = 13;
    localparam int   DRAIN_CYCLES = 40;      // pipe is 24 deep
    localparam int   CYCLE_LIMIT  = 200000;
    localparam int   RANDOM_PHASES   = 10;
    localparam int   ITEMS_PER_PHASE = 75;
    localparam logic [ADDR_W-1:0] ADDR_RANGE_MIN = {REG_MIN_IDX, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_RANGE_MAX = {REG_MAX_IDX, 2'b00};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_LOWEST  = 32'sh8000_0000;
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_HIGHEST = 32'sh7FFF_FFFF;

    logic                    clk;
    logic                    rst_n          = 1'b0;
    logic                    psel           = 1'b0;
    logic                    penable        = 1'b0;
    logic                    pwrite         = 1'b0;
    logic [ADDR_W-1:0]       paddr          = '0;
    logic [DATA_W-1:0]       pwdata         = '0;
    logic [DATA_W-1:0]       prdata;
    logic                    pready;
    logic                    s_axis_tvalid  = 1'b0;
    logic                    s_axis_tready;
    logic [SAMPLE_WIDTH-1:0] s_axis_tdata   = '0;   // [31:0] sample_value
    logic                    s_axis_tuser   = 1'b0; // [0] no_data
    logic                    m_axis_tvalid;
    logic                    m_axis_tready  = 1'b0;
    logic [23:0]             m_axis_tdata;          // [7:0] red, [15:8] green, [23:16] blue

    // mirror of the range registers, updated at the write edge
    logic signed [SAMPLE_WIDTH-1:0] range_min_cfg = '0;
    logic signed [SAMPLE_WIDTH-1:0] range_max_cfg = SAMPLE_WIDTH'(ONE);

    sample_item_t pending_samples[$];
    color_t       expected_colors[$];
    logic         sample_taken   = 1'b0;
    bit           steady_flow    = 1'b0;
    int           mismatch_count = 0;
    int           cycle_count    = 0;

    jet_false_color_map u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // color prediction
    // ------------------------------------------------------------------

    // slope 127.5 per unit of gray, half rounded up, capped at full scale
    function automatic logic [7:0] jet_ramp(input u64_t pos);
        u64_t level;
        level = (pos * 255 + ONE) >> (FRACTION_BITS + 1);
        return (level > u64_t'(LEVEL_MAX)) ? LEVEL_MAX : level[7:0];
    endfunction

    // gray in [0,8] with FRACTION_BITS fraction bits, truncated
    function automatic u64_t scale_to_gray(input logic signed [SAMPLE_WIDTH-1:0] sample,
                                           input logic signed [SAMPLE_WIDTH-1:0] lo,
                                           input logic signed [SAMPLE_WIDTH-1:0] hi);
        longint span;
        longint offset;
        span   = longint'(hi) - longint'(lo);
        offset = longint'(sample) - longint'(lo);
        // empty or inverted range and samples under the floor sit at the bottom
        if (span <= 0 || offset <= 0)
            return 0;
        if (offset >= span)
            return 8 * ONE;
        return (u64_t'(offset) << (FRACTION_BITS + 3)) / u64_t'(span);
    endfunction

    function automatic color_t jet_color_of(input logic [SAMPLE_WIDTH-1:0] sample,
                                            input logic no_data);
        color_t c;
        u64_t   g;
        if (no_data)
        begin
            c.red   = NO_DATA_LEVEL;
            c.green = NO_DATA_LEVEL;
            c.blue  = NO_DATA_LEVEL;
            return c;
        end
        g = scale_to_gray(sample, range_min_cfg, range_max_cfg);
        // five segments, bounds at gray 1, 3, 5 and 7
        if (g <= ONE)
        begin
            c.red = 8'd0;               c.green = 8'd0;               c.blue = jet_ramp(g + ONE);
        end
        else if (g <= 3 * ONE)
        begin
            c.red = 8'd0;               c.green = jet_ramp(g - ONE);  c.blue = LEVEL_MAX;
        end
        else if (g <= 5 * ONE)
        begin
            c.red = jet_ramp(g - 3 * ONE); c.green = LEVEL_MAX;       c.blue = jet_ramp(5 * ONE - g);
        end
        else if (g <= 7 * ONE)
        begin
            c.red = LEVEL_MAX;          c.green = jet_ramp(7 * ONE - g); c.blue = 8'd0;
        end
        else
        begin
            c.red = jet_ramp(9 * ONE - g); c.green = 8'd0;            c.blue = 8'd0;
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // sample driver and color sink, both move at the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : sample_driver
        sample_item_t item;
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            // offer the next sample once the current one has gone through
            if (!s_axis_tvalid || sample_taken)
            begin
                if (pending_samples.size() != 0 &&
                    (steady_flow || $urandom_range(99) >= IDLE_PCT))
                begin
                    item = pending_samples.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= item.value;
                    s_axis_tuser  <= item.no_data;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            m_axis_tready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------
    // monitor: accepted samples turn into expected colors, results are checked
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : color_monitor
        color_t want;
        color_t got;
        if (!rst_n)
            sample_taken <= 1'b0;
        else
        begin
            sample_taken <= s_axis_tvalid && s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                expected_colors = {expected_colors, jet_color_of(s_axis_tdata, s_axis_tuser)};
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (expected_colors.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t: color transaction with none expected, actual r=%0d g=%0d b=%0d",
                             $time, got.red, got.green, got.blue);
                end
                else
                begin
                    want = expected_colors.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue)
                    begin
                        mismatch_count++;
                        $display("%0t: color mismatch, expected r=%0d g=%0d b=%0d actual r=%0d g=%0d b=%0d",
                                 $time, want.red, want.green, want.blue,
                                 got.red, got.green, got.blue);
                    end
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL jet_false_color_map");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // setup cycle then access cycle; the mirror follows at the write edge
    task automatic write_reg(input logic [ADDR_W-1:0] addr,
                             input logic signed [SAMPLE_WIDTH-1:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = DATA_W'(value);
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (addr == ADDR_RANGE_MIN)
            range_min_cfg = value;
        else
            range_max_cfg = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_range(input logic signed [SAMPLE_WIDTH-1:0] lo,
                             input logic signed [SAMPLE_WIDTH-1:0] hi);
        write_reg(ADDR_RANGE_MIN, lo);
        write_reg(ADDR_RANGE_MAX, hi);
    endtask

    // sender holds off until every color is back and the pipe is empty
    task automatic drain_pipe();
        while (pending_samples.size() != 0 || s_axis_tvalid || expected_colors.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic queue_sample(input logic [SAMPLE_WIDTH-1:0] value, input logic no_data);
        sample_item_t item;
        item.value   = value;
        item.no_data = no_data;
        pending_samples = {pending_samples, item};
    endtask

    // mostly inside the range, with segment bounds, both sides of it and raw noise
    function automatic logic [SAMPLE_WIDTH-1:0] random_sample(
        input logic signed [SAMPLE_WIDTH-1:0] lo,
        input logic signed [SAMPLE_WIDTH-1:0] hi);
        longint span;
        int     pick;
        u64_t   r;
        span = longint'(hi) - longint'(lo);
        pick = $urandom_range(99);
        r    = {$urandom(), $urandom()};
        if (span <= 0 || pick < 15)
            return $urandom();
        if (pick < 30)
            return SAMPLE_WIDTH'(longint'(lo) + span * longint'($urandom_range(8)) / 8
                                + longint'($urandom_range(4)) - 2);
        if (pick < 38)
            return SAMPLE_WIDTH'(longint'(lo) - longint'($urandom_range(1000)));
        if (pick < 46)
            return SAMPLE_WIDTH'(longint'(hi) + longint'($urandom_range(1000)));
        return SAMPLE_WIDTH'(longint'(lo) + longint'(r % u64_t'(span + 1)));
    endfunction

    // mostly proper ranges of every width, now and then inverted or full scale
    task automatic random_range(output logic signed [SAMPLE_WIDTH-1:0] lo,
                                output logic signed [SAMPLE_WIDTH-1:0] hi);
        int     kind;
        longint span;
        logic signed [SAMPLE_WIDTH-1:0] t;
        kind = $urandom_range(9);
        lo   = $urandom();
        hi   = $urandom();
        if (kind == 0)
        begin
            // maximum not above minimum
            if (hi > lo)
            begin
                t  = lo;
                lo = hi;
                hi = t;
            end
        end
        else if (kind == 1)
        begin
            lo = SAMPLE_LOWEST;
            hi = SAMPLE_HIGHEST;
        end
        else
        begin
            if (kind == 2)
                span = longint'($urandom_range(16, 1));
            else
                span = longint'($urandom()) >> $urandom_range(31);
            if (span == 0)
                span = 1;
            if (longint'(lo) + span > longint'(SAMPLE_HIGHEST))
                lo = SAMPLE_WIDTH'(longint'(SAMPLE_HIGHEST) - span);
            hi = SAMPLE_WIDTH'(longint'(lo) + span);
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        logic signed [SAMPLE_WIDTH-1:0] lo;
        logic signed [SAMPLE_WIDTH-1:0] hi;
        int phase;
        int n;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset range 0..1.0: field extremes and both sides of each segment bound
        queue_sample(SAMPLE_LOWEST, 1'b0);
        queue_sample(SAMPLE_HIGHEST, 1'b0);
        queue_sample(32'hFFFF_FFFF, 1'b0);
        queue_sample(32'd0, 1'b0);
        queue_sample(32'd8192, 1'b0);
        queue_sample(32'd8193, 1'b0);
        queue_sample(32'd24576, 1'b0);
        queue_sample(32'd24577, 1'b0);
        queue_sample(32'd40960, 1'b0);
        queue_sample(32'd40961, 1'b0);
        queue_sample(32'd57344, 1'b0);
        queue_sample(32'd57345, 1'b0);
        queue_sample(32'd65535, 1'b0);
        queue_sample(32'd65536, 1'b0);
        queue_sample(32'd0, 1'b1);
        queue_sample(SAMPLE_HIGHEST, 1'b1);
        drain_pipe();

        // empty range, then fully inverted range: gray stays at the bottom
        set_range(32'sd65536, 32'sd65536);
        queue_sample(32'd65536, 1'b0);
        queue_sample(32'd0, 1'b0);
        drain_pipe();
        set_range(SAMPLE_HIGHEST, SAMPLE_LOWEST);
        queue_sample(32'd0, 1'b0);
        queue_sample(SAMPLE_HIGHEST, 1'b0);
        drain_pipe();

        // widest range the registers hold
        set_range(SAMPLE_LOWEST, SAMPLE_HIGHEST);
        queue_sample(SAMPLE_LOWEST, 1'b0);
        queue_sample(SAMPLE_HIGHEST, 1'b0);
        queue_sample(32'd0, 1'b0);
        queue_sample(32'hFFFF_FFFF, 1'b0);
        queue_sample(32'h5555_5555, 1'b1);
        drain_pipe();

        // random ranges, one per phase, with a quiet phase of full throughput
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            random_range(lo, hi);
            set_range(lo, hi);
            steady_flow = (phase == 3);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                queue_sample(random_sample(lo, hi), $urandom_range(99) < 10);
            drain_pipe();
        end
        steady_flow = 1'b0;

        if (mismatch_count == 0)
            $display("PASS jet_false_color_map");
        else
            $display("FAIL jet_false_color_map");
        $finish;
    end

endmodule
